// File: rtl/trading_script_lexer_assert.svh
// Assertion helpers for the lexer modules, included by tsl_back
`ifndef TRADING_SCRIPT_LEXER_ASSERT_SVH
`define TRADING_SCRIPT_LEXER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define TSL_ASSERT_IMPLY(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lexer assertion failed");

// Next-cycle implication, checked outside reset
`define TSL_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lexer assertion failed");

`endif

// File: rtl/tsl_pkg.sv
package tsl_pkg;

    localparam int OFFSET_BITS_DEF  = 16;
    localparam int KW_MAX_CHARS_DEF = 9;
    localparam int KW_CHARS         = 9;
    localparam int KW_COUNT         = 13;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Token types
    localparam logic [5:0] TOK_EOF     = 6'd0;
    localparam logic [5:0] TOK_IDENT   = 6'd1;
    localparam logic [5:0] TOK_NUMBER  = 6'd2;
    localparam logic [5:0] TOK_STRING  = 6'd3;
    localparam logic [5:0] TOK_LPAREN  = 6'd4;
    localparam logic [5:0] TOK_RPAREN  = 6'd5;
    localparam logic [5:0] TOK_LBRACK  = 6'd6;
    localparam logic [5:0] TOK_RBRACK  = 6'd7;
    localparam logic [5:0] TOK_SEMI    = 6'd8;
    localparam logic [5:0] TOK_COMMA   = 6'd9;
    localparam logic [5:0] TOK_PLUS    = 6'd10;
    localparam logic [5:0] TOK_MINUS   = 6'd11;
    localparam logic [5:0] TOK_STAR    = 6'd12;
    localparam logic [5:0] TOK_SLASH   = 6'd13;
    localparam logic [5:0] TOK_COLON   = 6'd14;
    localparam logic [5:0] TOK_LE      = 6'd15;
    localparam logic [5:0] TOK_NE      = 6'd16;
    localparam logic [5:0] TOK_LT      = 6'd17;
    localparam logic [5:0] TOK_GE      = 6'd18;
    localparam logic [5:0] TOK_GT      = 6'd19;
    localparam logic [5:0] TOK_EQ      = 6'd20;
    localparam logic [5:0] TOK_ERROR   = 6'd33;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

    // Keyword table, text left-justified and zero padded
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
        {"IF",        56'h0}, {"THEN",      40'h0}, {"ELSE",  40'h0},
        {"BEGIN",     32'h0}, {"END",       48'h0}, {"VARIABLES"},
        {"VARS",      40'h0}, {"INPUTS",    24'h0}, {"AND",   48'h0},
        {"OR",        56'h0}, {"NOT",       48'h0}, {"TRUE",  40'h0},
        {"FALSE",     32'h0}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd9, 4'd4, 4'd6, 4'd3, 4'd2, 4'd3, 4'd4, 4'd5
    };
    localparam logic [5:0] KW_TYPE [KW_COUNT] = '{
        6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd30, 6'd31, 6'd32
    };

    typedef struct packed {
        logic [5:0]  ttype;
        logic [1:0]  err;
        logic [15:0] start;
        logic [15:0] len;
    } tok_t;

    typedef struct packed {
        tok_t [2:0]  tok;
        logic [15:0] line;
        logic [1:0]  cnt;
    } bundle_t;

    // Map a word to its keyword type, identifier when none matches
    function automatic logic [5:0] kw_lookup(input logic [KW_CHARS*8-1:0] word,
                                             input logic [3:0] len);
        logic [5:0] t;
        logic       hit;
        t = TOK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (len == KW_LEN[k]);
            for (int i = 0; i < KW_CHARS; i++) begin
                if (4'(i) < KW_LEN[k] &&
                    word[KW_CHARS*8-1-8*i -: 8] != KW_TEXT[k][KW_CHARS*8-1-8*i -: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                t = KW_TYPE[k];
            end
        end
        return t;
    endfunction

    // Single-byte punctuation, zero when the byte is not one
    function automatic logic [5:0] punct_type(input logic [7:0] c);
        logic [5:0] t;
        unique case (c)
            8'h28:   t = TOK_LPAREN;
            8'h29:   t = TOK_RPAREN;
            8'h5B:   t = TOK_LBRACK;
            8'h5D:   t = TOK_RBRACK;
            8'h3B:   t = TOK_SEMI;
            8'h2C:   t = TOK_COMMA;
            8'h2B:   t = TOK_PLUS;
            8'h2D:   t = TOK_MINUS;
            8'h2A:   t = TOK_STAR;
            8'h3A:   t = TOK_COLON;
            8'h3D:   t = TOK_EQ;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/tsl_front.sv
module tsl_front
    import tsl_pkg::*;
#(
    parameter int OFFSET_BITS       = OFFSET_BITS_DEF,
    parameter int KEYWORD_MAX_CHARS = KW_MAX_CHARS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  source_byte,
    input  logic        q_full,
    output logic        push,
    output bundle_t     push_data
);

    localparam int OB = OFFSET_BITS;
    localparam int IW = $clog2(KEYWORD_MAX_CHARS);
    localparam int LW = $clog2(KEYWORD_MAX_CHARS + 2);
    localparam int DW = (OB + 1 > 16) ? OB + 1 : 16;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_NUM     = 4'd2;
    localparam logic [3:0] M_NUM_DOT = 4'd3;
    localparam logic [3:0] M_FRAC    = 4'd4;
    localparam logic [3:0] M_STR_SQ  = 4'd5;
    localparam logic [3:0] M_STR_DQ  = 4'd6;
    localparam logic [3:0] M_BLOCK   = 4'd7;
    localparam logic [3:0] M_SLASH   = 4'd8;
    localparam logic [3:0] M_LINE    = 4'd9;
    localparam logic [3:0] M_LESS    = 4'd10;
    localparam logic [3:0] M_GREATER = 4'd11;

    logic [3:0]    mode_reg, mode_next;
    logic [OB-1:0] start_reg, start_next;
    logic [OB-1:0] pos_reg, pos_next;
    logic [15:0]   line_reg, line_next;
    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    kbuf_reg [KEYWORD_MAX_CHARS];

    logic          accept;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [7:0]    wr_char;
    logic          line_inc;
    logic          do_idle;
    logic [1:0]    n;
    logic [5:0]    e_type [3];
    logic [1:0]    e_err [3];
    logic [OB:0]   e_st [3];
    logic [OB:0]   e_end [3];
    logic [OB:0]   cur;
    logic [OB:0]   dot;
    logic [7:0]    c;
    logic [7:0]    c_up;
    logic          is_alpha, is_digit, is_istart;
    logic [5:0]    single;
    logic [5:0]    kw_type;
    logic [KW_CHARS*8-1:0] word;
    logic [OB:0]   diff [3];
    logic [DW-1:0] diff_w [3];

    assign accept   = in_valid && in_ready;
    assign in_ready = !q_full;
    assign c        = source_byte;
    assign is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    assign is_digit = (c >= 8'h30 && c <= 8'h39);
    assign is_istart = is_alpha || c == 8'h5F || c[7];
    assign c_up     = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    assign single   = punct_type(c);
    assign cur      = {1'b0, pos_reg};
    assign dot      = (cur != '0) ? cur - 1'b1 : '0;

    // Gather the stored word and classify it
    always_comb
    begin
        for (int i = 0; i < KW_CHARS; i++)
        begin
            word[KW_CHARS*8-1-8*i -: 8] = kbuf_reg[i];
        end
        kw_type = kw_lookup(word, (len_reg <= LW'(KW_CHARS)) ? 4'(len_reg) : 4'd0);
    end

    // Scanner next state and emitted tokens
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        wr_en      = 1'b0;
        wr_idx     = len_reg[IW-1:0];
        wr_char    = c_up;
        line_inc   = 1'b0;
        do_idle    = 1'b0;
        n          = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            e_type[k] = TOK_EOF;
            e_err[k]  = ERR_NONE;
            e_st[k]   = '0;
            e_end[k]  = '0;
        end
        if (kind)
        begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    e_type[n] = kw_type; e_st[n] = {1'b0, start_reg}; e_end[n] = cur;
                    n = n + 2'd1;
                end
                M_NUM, M_FRAC, M_SLASH, M_LESS, M_GREATER:
                begin
                    e_type[n] = (mode_reg == M_SLASH) ? TOK_SLASH :
                                (mode_reg == M_LESS) ? TOK_LT :
                                (mode_reg == M_GREATER) ? TOK_GT : TOK_NUMBER;
                    e_st[n] = {1'b0, start_reg}; e_end[n] = cur;
                    n = n + 2'd1;
                end
                M_NUM_DOT:
                begin
                    e_type[n] = TOK_NUMBER; e_st[n] = {1'b0, start_reg}; e_end[n] = dot;
                    n = n + 2'd1;
                    e_type[n] = TOK_ERROR; e_err[n] = ERR_UNEXPECTED;
                    e_st[n] = dot; e_end[n] = dot + 1'b1;
                    n = n + 2'd1;
                end
                M_STR_SQ, M_STR_DQ:
                begin
                    e_type[n] = TOK_ERROR; e_err[n] = ERR_UNTERM_STR;
                    e_st[n] = {1'b0, start_reg}; e_end[n] = cur;
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode_next  = M_IDLE;
            start_next = pos_reg;
            e_type[n] = TOK_EOF; e_st[n] = cur; e_end[n] = cur;
            n = n + 2'd1;
        end
        else
        begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    if (is_istart || is_digit)
                    begin
                        if (len_reg < LW'(KEYWORD_MAX_CHARS))
                        begin
                            wr_en    = 1'b1;
                            len_next = len_reg + 1'b1;
                        end
                        else
                        begin
                            len_next = LW'(KEYWORD_MAX_CHARS + 1);
                        end
                    end
                    else
                    begin
                        e_type[n] = kw_type; e_st[n] = {1'b0, start_reg}; e_end[n] = cur;
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (c == 8'h2E)
                    begin
                        mode_next = M_NUM_DOT;
                    end
                    else if (!is_digit)
                    begin
                        e_type[n] = TOK_NUMBER; e_st[n] = {1'b0, start_reg}; e_end[n] = cur;
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_NUM_DOT:
                begin
                    if (is_digit)
                    begin
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        e_type[n] = TOK_NUMBER; e_st[n] = {1'b0, start_reg}; e_end[n] = dot;
                        n = n + 2'd1;
                        e_type[n] = TOK_ERROR; e_err[n] = ERR_UNEXPECTED;
                        e_st[n] = dot; e_end[n] = dot + 1'b1;
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (!is_digit)
                    begin
                        e_type[n] = TOK_NUMBER; e_st[n] = {1'b0, start_reg}; e_end[n] = cur;
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_STR_SQ, M_STR_DQ:
                begin
                    if (c == ((mode_reg == M_STR_SQ) ? 8'h27 : 8'h22))
                    begin
                        e_type[n] = TOK_STRING; e_st[n] = {1'b0, start_reg};
                        e_end[n] = cur + 1'b1;
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (c == 8'h0A)
                    begin
                        line_inc = 1'b1;
                    end
                end
                M_BLOCK:
                begin
                    if (c == 8'h7D)
                    begin
                        mode_next = M_IDLE;
                    end
                    else if (c == 8'h0A)
                    begin
                        line_inc = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (c == 8'h2F)
                    begin
                        mode_next = M_LINE;
                    end
                    else
                    begin
                        e_type[n] = TOK_SLASH; e_st[n] = {1'b0, start_reg}; e_end[n] = cur;
                        n = n + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_LINE:
                begin
                    do_idle = (c == 8'h0A);
                end
                M_LESS:
                begin
                    e_type[n] = (c == 8'h3D) ? TOK_LE : (c == 8'h3E) ? TOK_NE : TOK_LT;
                    e_st[n] = {1'b0, start_reg};
                    e_end[n] = (c == 8'h3D || c == 8'h3E) ? cur + 1'b1 : cur;
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                    do_idle = !(c == 8'h3D || c == 8'h3E);
                end
                M_GREATER:
                begin
                    e_type[n] = (c == 8'h3D) ? TOK_GE : TOK_GT;
                    e_st[n] = {1'b0, start_reg};
                    e_end[n] = (c == 8'h3D) ? cur + 1'b1 : cur;
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                    do_idle = (c != 8'h3D);
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            // Start a new token from the idle state
            if (do_idle)
            begin
                mode_next  = M_IDLE;
                start_next = pos_reg;
                priority if (c == 8'h20 || c == 8'h0D || c == 8'h09)
                begin
                end
                else if (c == 8'h0A)
                begin
                    line_inc = 1'b1;
                end
                else if (c == 8'h7B)
                begin
                    mode_next = M_BLOCK;
                end
                else if (c == 8'h2F)
                begin
                    mode_next = M_SLASH;
                end
                else if (c == 8'h3C)
                begin
                    mode_next = M_LESS;
                end
                else if (c == 8'h3E)
                begin
                    mode_next = M_GREATER;
                end
                else if (c == 8'h27)
                begin
                    mode_next = M_STR_SQ;
                end
                else if (c == 8'h22)
                begin
                    mode_next = M_STR_DQ;
                end
                else if (single != 6'd0)
                begin
                    e_type[n] = single; e_st[n] = cur; e_end[n] = cur + 1'b1;
                    n = n + 2'd1;
                end
                else if (is_istart)
                begin
                    wr_en     = 1'b1;
                    wr_idx    = '0;
                    len_next  = LW'(1);
                    mode_next = M_IDENT;
                end
                else if (is_digit)
                begin
                    mode_next = M_NUM;
                end
                else
                begin
                    e_type[n] = TOK_ERROR; e_err[n] = ERR_UNEXPECTED;
                    e_st[n] = cur; e_end[n] = cur + 1'b1;
                    n = n + 2'd1;
                end
            end
        end
    end

    assign pos_next  = (!kind && pos_reg != '1) ? pos_reg + 1'b1 : pos_reg;
    assign line_next = (line_inc && line_reg != 16'hFFFF) ? line_reg + 16'd1 : line_reg;

    // Build the bundle with clamped, saturated lengths
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff[k]   = (e_end[k] > e_st[k]) ? e_end[k] - e_st[k] : '0;
            diff_w[k] = DW'(diff[k]);
            push_data.tok[k].ttype = e_type[k];
            push_data.tok[k].err   = e_err[k];
            push_data.tok[k].start = 16'(e_st[k][OB-1:0]);
            push_data.tok[k].len   = (diff_w[k] > DW'(17'h0FFFF)) ? 16'hFFFF :
                                     16'(diff_w[k]);
        end
        push_data.line = line_reg;
        push_data.cnt  = n;
    end

    assign push = accept && (n != 2'd0);

    // Advance scanner state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= 16'd1;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            line_reg  <= line_next;
            len_reg   <= len_next;
        end
    end

    // Hold word characters
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            kbuf_reg[wr_idx] <= wr_char;
        end
    end

endmodule

// File: rtl/tsl_queue.sv
module tsl_queue
    import tsl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    q_valid,
    output bundle_t q_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t       mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/tsl_back.sv
`include "trading_script_lexer_assert.svh"
module tsl_back
    import tsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  bundle_t     q_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_type,
    output logic [1:0]  error_code,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic [15:0] line_number,
    output logic        last_of_run
);

    bundle_t    cur_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       last;
    tok_t       tok;

    assign last      = (idx_reg == cur_reg.cnt - 2'd1);
    assign pop       = q_valid && (!valid_reg || (out_ready && last));
    assign out_valid = valid_reg;
    assign tok       = cur_reg.tok[idx_reg];

    assign token_type   = tok.ttype;
    assign error_code   = tok.err;
    assign start_offset = tok.start;
    assign token_length = tok.len;
    assign line_number  = cur_reg.line;
    assign last_of_run  = last;

    // Step through the bundle, load the next on its last transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && out_ready)
        begin
            valid_reg <= !last;
            idx_reg   <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // Hold the bundle payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_data;
        end
    end

    `TSL_ASSERT_IMPLY(a_idx_in_range, valid_reg, idx_reg < cur_reg.cnt)
    `TSL_ASSERT_IMPLY(a_bundle_nonempty, valid_reg, cur_reg.cnt != 2'd0)
    `TSL_ASSERT_NEXT(a_stall_holds, valid_reg && !out_ready, valid_reg && $stable(idx_reg))

endmodule

// File: rtl/trading_script_lexer.sv
// Streaming lexer for a small trading-script language.
// Input channel (in_valid/in_ready): one source byte per transfer with kind 0,
// or an end-of-source marker with kind 1. Output channel (out_valid/out_ready):
// one token per transfer with type, error code, start offset, length and line;
// last_of_run marks the final token caused by one input transfer.
// Throughput: one input per cycle while the token queue has room. The output
// side sends one token per cycle while out_ready is high, so an input yielding
// up to three tokens holds that side until all are sent; the four-entry bundle
// queue between the scanner and the output stage absorbs such bursts.
// Path: the queue is written at the input transfer, and the output stage then
// loads the bundle once it is idle or sends its last token, raising out_valid.
// Reset: scanner idle, position 0, line 1, queue empty, out_valid low.
// When the receiver stalls, the current token holds; the queue fills and
// then in_ready drops until space frees.
module trading_script_lexer
    import tsl_pkg::*;
#(
    parameter int OFFSET_BITS       = OFFSET_BITS_DEF,
    parameter int KEYWORD_MAX_CHARS = KW_MAX_CHARS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [7:0]  source_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_type,
    output logic [1:0]  error_code,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic [15:0] line_number,
    output logic        last_of_run
);

    logic    q_full;
    logic    push;
    bundle_t push_data;
    logic    pop;
    logic    q_valid;
    bundle_t q_data;

    tsl_front #(
        .OFFSET_BITS       (OFFSET_BITS),
        .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .source_byte (source_byte),
        .q_full      (q_full),
        .push        (push),
        .push_data   (push_data)
    );

    tsl_queue #(
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    tsl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_type   (token_type),
        .error_code   (error_code),
        .start_offset (start_offset),
        .token_length (token_length),
        .line_number  (line_number),
        .last_of_run  (last_of_run)
    );

endmodule
